>>> hdl/pci_pkg.sv
package pci_pkg;

  // port field widths
  localparam int LET_W = 5;
  localparam int COL_W = 5;
  localparam int PER_W = 6;
  localparam int IDX_W = 17;

  // fraction bits of the coincidence index and the value 1.0
  localparam int FRAC_BITS = 16;
  localparam logic [IDX_W-1:0] ONE_Q16 = 17'h10000;

endpackage

>>> hdl/pci_ram.sv
module pci_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> hdl/pci_pairmul.sv
module pci_pairmul #(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic [W-1:0]   a,
  output logic [2*W-1:0] prod_r
);

  logic [W-1:0] a_dec;

  // a * (a - 1), zero for a == 0
  assign a_dec = (a == '0) ? '0 : a - W'(1);

  always_ff @(posedge clk) begin
    prod_r <= a * a_dec;
  end

endmodule

>>> hdl/pci_div.sv
module pci_div #(
  parameter int XW = 71,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [XW-1:0] x,
  input  logic [DW-1:0] d,
  output logic          done_r,
  output logic [XW-1:0] q_r
);

  localparam int CNT_W = $clog2(XW + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    d_r;
  logic [DW:0]      rem_sh;
  logic             fits;

  // one restoring step per cycle, quotient bits shift in at the bottom
  assign rem_sh = {rem_r, q_r[XW-1]};
  assign fits   = rem_sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(XW);
        rem_r <= '0;
        q_r   <= x;
        d_r   <= d;
      end else if (cnt_r != '0) begin
        rem_r <= fits ? DW'(rem_sh - {1'b0, d_r}) : rem_sh[DW-1:0];
        q_r   <= {q_r[XW-2:0], fits};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/periodic_coincidence_index.sv
// Per-column index of coincidence over a periodic text.
// Input: pulse start with in_letter / in_last_symbol while busy is low; the
// symbol is taken at that edge. Symbol i lands in column i mod period.
// Configuration: cfg_we with cfg_data writes period (reset value 1); write
// only while busy is low.
// Load: each symbol reads its histogram count, then writes it back, as the
// read of the count memory is registered.
// Report: after a symbol with in_last_symbol, one result per column appears
// on out_* for one cycle each, marked by out_valid. Per column each letter
// passes through the shared pair multiplier, then the bit-serial divider
// (XW = 2*COUNT_BITS + clog2(ALPHABET_SIZE) + 17 bits) forms the index; the
// divider is skipped when the column is short or its index clamps to one.
// The last column adds a second divider pass for the mean, carried on
// out_mean_index with out_last_result.
// After reset and after each report the block clears its stores, one entry
// per cycle, MAX_PERIOD*ALPHABET_SIZE entries in all, with busy high.
// The receiver cannot stall; results are simply presented.
module periodic_coincidence_index #(
  parameter int MAX_PERIOD    = 32,
  parameter int ALPHABET_SIZE = 32,
  parameter int COUNT_BITS    = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [pci_pkg::LET_W-1:0]     in_letter,
  input  logic                          in_last_symbol,
  input  logic                          cfg_we,
  input  logic [pci_pkg::PER_W-1:0]     cfg_data,
  output logic                          out_valid,
  output logic [pci_pkg::COL_W-1:0]     out_column,
  output logic [pci_pkg::IDX_W-1:0]     out_column_index,
  output logic [pci_pkg::LET_W-1:0]     out_top_letter,
  output logic                          out_too_short,
  output logic [pci_pkg::IDX_W-1:0]     out_mean_index,
  output logic                          out_last_result
);

  import pci_pkg::*;

  localparam int DEPTH = MAX_PERIOD * ALPHABET_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
  localparam int PEW   = $clog2(MAX_PERIOD + 1);
  localparam int LW    = $clog2(ALPHABET_SIZE);
  localparam int CB    = COUNT_BITS;
  localparam int PW    = 2 * CB;
  localparam int NUMW  = PW + LW;
  localparam int XW    = NUMW + FRAC_BITS + 1;
  localparam int SW    = IDX_W + PEW;
  localparam logic [CB-1:0] CAP = {CB{1'b1}};

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_LWR  = 4'd2;
  localparam logic [3:0] S_RCOL = 4'd3;
  localparam logic [3:0] S_RDAT = 4'd4;
  localparam logic [3:0] S_RACC = 4'd5;
  localparam logic [3:0] S_RDEN = 4'd6;
  localparam logic [3:0] S_RDW  = 4'd7;
  localparam logic [3:0] S_RDIV = 4'd8;
  localparam logic [3:0] S_RFIN = 4'd9;
  localparam logic [3:0] S_MDIV = 4'd10;

  logic [3:0]       state_r;
  logic [PER_W-1:0] period_r;
  logic [AW-1:0]    clr_r;
  logic [CW-1:0]    cur_r;
  logic [CW-1:0]    ldcol_r;
  logic [LW-1:0]    ldlet_r;
  logic             last_r;
  logic [CW-1:0]    rep_r;
  logic [LW-1:0]    j_r;
  logic [CB-1:0]    n_r;
  logic [NUMW-1:0]  acc_r;
  logic [LW-1:0]    best_r;
  logic [CB-1:0]    bestv_r;
  logic [IDX_W-1:0] ic_r;
  logic             short_r;
  logic [SW-1:0]    sum_r;

  logic [PEW-1:0]   p_eff;
  logic             let_ok;
  logic [CW-1:0]    col_ld;
  logic [CW-1:0]    col_nx;
  logic             rep_last;
  logic [SW-1:0]    sum_nxt;

  logic             cnt_we, len_we;
  logic [AW-1:0]    cnt_waddr, cnt_raddr;
  logic [CW-1:0]    len_waddr, len_raddr;
  logic [CB-1:0]    cnt_wdata, len_wdata, cnt_rdata, len_rdata;

  logic [CB-1:0]    mul_a;
  logic [PW-1:0]    mul_p;
  logic             div_start, div_done;
  logic [XW-1:0]    div_x, div_q;
  logic [PW-1:0]    div_d;

  // clamp the period into 1..MAX_PERIOD
  always_comb begin
    if (period_r == '0) begin
      p_eff = PEW'(1);
    end else if ({1'b0, period_r} > 7'(MAX_PERIOD)) begin
      p_eff = PEW'(MAX_PERIOD);
    end else begin
      p_eff = PEW'(period_r);
    end
  end

  assign let_ok   = 7'(in_letter) < 7'(ALPHABET_SIZE);
  assign col_ld   = (PEW'(cur_r) >= p_eff) ? '0 : cur_r;
  assign col_nx   = (PEW'(col_ld) + PEW'(1) >= p_eff) ? '0 : CW'(col_ld + CW'(1));
  assign rep_last = PEW'(rep_r) + PEW'(1) >= p_eff;
  assign sum_nxt  = sum_r + SW'(ic_r);
  assign busy     = state_r != S_IDLE;

  // count memory read address
  always_comb begin
    unique case (state_r)
      S_IDLE:  cnt_raddr = AW'(32'(col_ld) * ALPHABET_SIZE + 32'(in_letter));
      S_RCOL:  cnt_raddr = AW'(32'(rep_r) * ALPHABET_SIZE);
      default: cnt_raddr = AW'(32'(rep_r) * ALPHABET_SIZE + 32'(j_r) + 1);
    endcase
    len_raddr = (state_r == S_IDLE) ? col_ld : rep_r;
  end

  // write back on load, zero on the clearing sweep
  always_comb begin
    cnt_we    = (state_r == S_CLR) || (state_r == S_LWR);
    len_we    = (state_r == S_CLR && clr_r < AW'(MAX_PERIOD)) || (state_r == S_LWR);
    if (state_r == S_CLR) begin
      cnt_waddr = clr_r;
      cnt_wdata = '0;
      len_waddr = CW'(clr_r);
      len_wdata = '0;
    end else begin
      cnt_waddr = AW'(32'(ldcol_r) * ALPHABET_SIZE + 32'(ldlet_r));
      cnt_wdata = (cnt_rdata == CAP) ? cnt_rdata : cnt_rdata + CB'(1);
      len_waddr = ldcol_r;
      len_wdata = (len_rdata == CAP) ? len_rdata : len_rdata + CB'(1);
    end
  end

  pci_ram #(.WIDTH(CB), .DEPTH(DEPTH)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  pci_ram #(.WIDTH(CB), .DEPTH(MAX_PERIOD)) u_len (
    .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
    .raddr(len_raddr), .rdata(len_rdata)
  );

  // shared pair multiplier: letter counts, then the column length
  assign mul_a = (state_r == S_RDAT) ? cnt_rdata : n_r;

  pci_pairmul #(.W(CB)) u_mul (.clk(clk), .a(mul_a), .prod_r(mul_p));

  // shared divider: column index, then the mean
  always_comb begin
    div_start = 1'b0;
    div_x     = {acc_r, {(FRAC_BITS + 1){1'b0}}};
    div_d     = mul_p;
    if (state_r == S_RDW) begin
      div_start = (n_r >= CB'(2)) && ({{LW{1'b0}}, mul_p} > acc_r);
    end else if (state_r == S_RFIN) begin
      div_start = rep_last;
      div_x     = XW'(sum_nxt + SW'(p_eff >> 1));
      div_d     = PW'(p_eff);
    end
  end

  pci_div #(.XW(XW), .DW(PW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .x(div_x), .d(div_d),
    .done_r(div_done), .q_r(div_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      period_r  <= PER_W'(1);
      clr_r     <= '0;
      cur_r     <= '0;
      sum_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        period_r <= cfg_data;
      end
      unique case (state_r)
        S_CLR: begin
          cur_r <= '0;
          sum_r <= '0;
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(DEPTH - 1)) begin
            clr_r   <= '0;
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            ldcol_r <= col_ld;
            ldlet_r <= LW'(in_letter);
            last_r  <= in_last_symbol;
            rep_r   <= '0;
            sum_r   <= '0;
            if (let_ok) begin
              cur_r   <= col_nx;
              state_r <= S_LWR;
            end else if (in_last_symbol) begin
              state_r <= S_RCOL;
            end
          end
        end
        S_LWR: begin
          state_r <= last_r ? S_RCOL : S_IDLE;
        end
        S_RCOL: begin
          j_r     <= '0;
          acc_r   <= '0;
          best_r  <= '0;
          bestv_r <= '0;
          state_r <= S_RDAT;
        end
        S_RDAT: begin
          if (j_r == '0) begin
            n_r <= len_rdata;
          end
          if (cnt_rdata > bestv_r) begin
            bestv_r <= cnt_rdata;
            best_r  <= j_r;
          end
          state_r <= S_RACC;
        end
        S_RACC: begin
          acc_r <= acc_r + NUMW'(mul_p);
          if (j_r == LW'(ALPHABET_SIZE - 1)) begin
            state_r <= S_RDEN;
          end else begin
            j_r     <= j_r + LW'(1);
            state_r <= S_RDAT;
          end
        end
        S_RDEN: begin
          state_r <= S_RDW;
        end
        S_RDW: begin
          short_r <= n_r < CB'(2);
          if (n_r < CB'(2)) begin
            ic_r    <= '0;
            state_r <= S_RFIN;
          end else if ({{LW{1'b0}}, mul_p} <= acc_r) begin
            ic_r    <= ONE_Q16;
            state_r <= S_RFIN;
          end else begin
            state_r <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (div_done) begin
            ic_r    <= IDX_W'((18'(div_q[IDX_W-1:0]) + 18'(1)) >> 1);
            state_r <= S_RFIN;
          end
        end
        S_RFIN: begin
          sum_r            <= sum_nxt;
          out_column       <= COL_W'(rep_r);
          out_column_index <= ic_r;
          out_top_letter   <= LET_W'(best_r);
          out_too_short    <= short_r;
          out_mean_index   <= '0;
          out_last_result  <= 1'b0;
          if (rep_last) begin
            state_r <= S_MDIV;
          end else begin
            out_valid <= 1'b1;
            rep_r     <= rep_r + CW'(1);
            state_r   <= S_RCOL;
          end
        end
        S_MDIV: begin
          if (div_done) begin
            out_valid       <= 1'b1;
            out_last_result <= 1'b1;
            out_mean_index  <= (div_q[SW-1:0] > SW'(ONE_Q16)) ? ONE_Q16
                                                              : IDX_W'(div_q[SW-1:0]);
            state_r         <= S_CLR;
          end
        end
        default: begin
          state_r <= S_CLR;
        end
      endcase
    end
  end

  // a result always comes while the block is still busy
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside report");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_short |-> out_column_index == '0)
    else $error("short column with nonzero index");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_column_index <= ONE_Q16 && out_mean_index <= ONE_Q16)
    else $error("index above one");

  a_mean_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> out_mean_index == '0)
    else $error("mean on a non-final result");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |=> state_r == S_CLR)
    else $error("no clearing sweep after report");

endmodule

>>> tb/tb_top.sv
module tb_top;
  import pci_pkg::*;

  localparam int NCOL     = 32;
  localparam int NLET     = 32;
  localparam int CAP      = 65535;
  localparam int WDOG_MAX = 200000;

  // one expected column report entry
  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [IDX_W-1:0] column_index;
    logic [LET_W-1:0] top_letter;
    logic             too_short;
    logic [IDX_W-1:0] mean_index;
    logic             last_result;
  } col_report_t;

  // directed stimulus row; chk marks rows whose report is typed in
  typedef struct {
    logic [LET_W-1:0] letter;
    logic             last;
    logic             chk;
    logic [IDX_W-1:0] ic;
    logic [LET_W-1:0] top;
    logic             short_col;
  } drow_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [LET_W-1:0] in_letter = '0;
  logic in_last_symbol = 1'b0;
  logic cfg_we = 1'b0;
  logic [PER_W-1:0] cfg_data = '0;
  logic out_valid;
  logic [COL_W-1:0] out_column;
  logic [IDX_W-1:0] out_column_index;
  logic [LET_W-1:0] out_top_letter;
  logic out_too_short;
  logic [IDX_W-1:0] out_mean_index;
  logic out_last_result;

  periodic_coincidence_index dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_letter(in_letter), .in_last_symbol(in_last_symbol),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_column(out_column),
    .out_column_index(out_column_index), .out_top_letter(out_top_letter),
    .out_too_short(out_too_short), .out_mean_index(out_mean_index),
    .out_last_result(out_last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the histogram state
  int unsigned hist [NCOL][NLET];
  int unsigned col_len [NCOL];
  int unsigned cur_col;
  logic [PER_W-1:0] period_reg;

  col_report_t pending_reports[$];
  int errors = 0;
  int n_results = 0;
  int n_symbols = 0;
  int n_texts = 0;
  int idle_pct = 0;
  int wdog = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic int unsigned live_period();
    if (period_reg == 0) return 1;
    if (period_reg > NCOL) return NCOL;
    return period_reg;
  endfunction

  task automatic clear_histograms();
    foreach (hist[c, j]) hist[c][j] = 0;
    foreach (col_len[c]) col_len[c] = 0;
    cur_col = 0;
  endtask

  // update histograms with one symbol and queue any report it triggers
  task automatic predict_symbol(input logic [LET_W-1:0] letter, input logic last);
    int unsigned p, c, ic, best, sum;
    longint unsigned n, num, den, q, r;
    col_report_t rep;
    p = live_period();
    c = (cur_col >= p) ? 0 : cur_col;
    if (hist[c][letter] < CAP) hist[c][letter]++;
    if (col_len[c] < CAP) col_len[c]++;
    cur_col = (c + 1 >= p) ? 0 : c + 1;
    if (!last) return;
    sum = 0;
    for (int unsigned k = 0; k < p; k++) begin
      n = col_len[k];
      rep = '0;
      rep.column = k[COL_W-1:0];
      if (n < 2) begin
        ic = 0;
        rep.too_short = 1'b1;
      end else begin
        num = 0;
        for (int j = 0; j < NLET; j++)
          if (hist[k][j] > 0) num += longint'(hist[k][j]) * (hist[k][j] - 1);
        den = n * (n - 1);
        if (num >= den) ic = 65536;
        else begin
          q = (num << 16) / den;
          r = (num << 16) % den;
          if (2 * r >= den) q++;
          ic = 32'(q);
        end
      end
      best = 0;
      for (int j = 1; j < NLET; j++) if (hist[k][j] > hist[k][best]) best = j;
      rep.column_index = ic[IDX_W-1:0];
      rep.top_letter = best[LET_W-1:0];
      sum += ic;
      if (k == p - 1) begin
        ic = (sum + p / 2) / p;
        if (ic > 65536) ic = 65536;
        rep.mean_index = ic[IDX_W-1:0];
        rep.last_result = 1'b1;
      end
      pending_reports = {pending_reports, rep};
    end
    clear_histograms();
    n_texts++;
  endtask

  // compare each strobed result against the oldest expectation
  always @(posedge clk) begin
    col_report_t want;
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected result, column", out_column, -1);
      end else begin
        want = pending_reports.pop_front();
        if (out_column != want.column)
          report_mismatch("column", out_column, want.column);
        if (out_column_index != want.column_index)
          report_mismatch("column_index", out_column_index, want.column_index);
        if (out_top_letter != want.top_letter)
          report_mismatch("top_letter", out_top_letter, want.top_letter);
        if (out_too_short != want.too_short)
          report_mismatch("too_short", out_too_short, want.too_short);
        if (out_mean_index != want.mean_index)
          report_mismatch("mean_index", out_mean_index, want.mean_index);
        if (out_last_result != want.last_result)
          report_mismatch("last_result", out_last_result, want.last_result);
      end
    end
  end

  // watchdog: count cycles with no transaction in either direction
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("watchdog expired, %0d results pending", pending_reports.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // drive one symbol; hold start until the block takes it
  task automatic send_symbol(input logic [LET_W-1:0] letter, input logic last);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_letter <= letter;
    in_last_symbol <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_symbol(letter, last);
    n_symbols++;
  endtask

  // write period with the block idle
  task automatic set_period(input logic [PER_W-1:0] value);
    while (pending_reports.size() != 0 || busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    period_reg = value;
  endtask

  // drop start and wait for every queued result
  task automatic drain();
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  drow_t dir_rows[$];

  task automatic add_row(input logic [LET_W-1:0] l, input logic last, input logic chk,
                         input int ic, input int top, input logic sh);
    drow_t d;
    d.letter = l; d.last = last; d.chk = chk;
    d.ic = ic[IDX_W-1:0]; d.top = top[LET_W-1:0]; d.short_col = sh;
    dir_rows = {dir_rows, d};
  endtask

  initial begin
    int unsigned len, pr;
    col_report_t hand;
    clear_histograms();
    period_reg = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: period 1 after reset, single-symbol text is too short
    add_row(5'd31, 1'b1, 1'b1, 0, 31, 1'b1);
    // two identical letters: index is exactly one
    add_row(5'd0, 1'b0, 1'b0, 0, 0, 1'b0);
    add_row(5'd0, 1'b1, 1'b1, 65536, 0, 1'b0);
    // two distinct letters: index zero, tie goes to lowest letter
    add_row(5'd31, 1'b0, 1'b0, 0, 0, 1'b0);
    add_row(5'd7, 1'b1, 1'b1, 0, 7, 1'b0);
    set_period(6'd1);
    foreach (dir_rows[i]) begin
      send_symbol(dir_rows[i].letter, dir_rows[i].last);
      if (dir_rows[i].chk) begin
        hand = '0;
        hand.column_index = dir_rows[i].ic;
        hand.top_letter = dir_rows[i].top;
        hand.too_short = dir_rows[i].short_col;
        hand.mean_index = dir_rows[i].ic;
        hand.last_result = 1'b1;
        pending_reports[pending_reports.size() - 1] = hand;
      end
    end
    drain();

    // extremes of period: zero, maximum, beyond maximum, with empty columns
    set_period(6'd0);
    send_symbol(5'd3, 1'b0);
    send_symbol(5'd3, 1'b1);
    drain();
    set_period(6'd32);
    for (int i = 0; i < 40; i++) send_symbol(i[4:0], i == 39);
    drain();
    set_period(6'd63);
    send_symbol(5'd16, 1'b1);
    drain();
    // period changed mid-text, column beyond the new period
    set_period(6'd5);
    for (int i = 0; i < 3; i++) send_symbol(5'd9, 1'b0);
    drain();
    set_period(6'd2);
    for (int i = 0; i < 4; i++) send_symbol(i[4:0], i == 3);
    drain();

    // random texts across idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 83;
        2: idle_pct = 0;
        default: idle_pct = 31;
      endcase
      for (int t = 0; t < 6; t++) begin
        pr = ($urandom_range(3, 0) == 0) ? $urandom_range(63, 0) : $urandom_range(6, 1);
        set_period(pr[PER_W-1:0]);
        len = $urandom_range(26, 1);
        for (int i = 0; i < len; i++) begin
          // skewed letters make repeats likely
          send_symbol(LET_W'($urandom_range(1, 0) ? $urandom_range(3, 0)
                                                   : $urandom_range(31, 0)),
                      i == len - 1);
        end
        drain();
      end
    end

    idle_pct = 0;
    $display("covered %0d symbols in %0d texts, %0d column results checked",
             n_symbols, n_texts, n_results);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
